// File: design/smf_pkg.sv
// Shared constants and types for the sliding median filter.
package smf_pkg;

  localparam int unsigned SMF_DEPTH    = 16;
  localparam int unsigned SMF_IDX_W    = $clog2(SMF_DEPTH);
  localparam int unsigned SMF_CNT_W    = $clog2(SMF_DEPTH + 1);
  localparam int unsigned SMF_SAMPLE_W = 16;
  localparam int unsigned SMF_LEN_W    = 5;

  localparam logic [SMF_LEN_W-1:0] SMF_LEN_RESET = SMF_LEN_W'(8);

  // A sample travelling around the ring of cells during ranking.
  typedef struct packed {
    logic [SMF_SAMPLE_W-1:0] value;
    logic [SMF_IDX_W-1:0]    idx;
    logic                    held;
  } probe_t;

endpackage

// File: design/smf_in_if.sv
// Input channel interface carrying one sample per beat.
interface smf_in_if
  import smf_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [SMF_SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: design/smf_out_if.sv
// Output channel interface carrying one median result per beat.
interface smf_out_if
  import smf_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [SMF_SAMPLE_W-1:0] median;
  logic [SMF_LEN_W-1:0]    samples_held;

  modport source (output valid, output median, output samples_held, input ready);
  modport sink   (input valid, input median, input samples_held, output ready);
endinterface

// File: design/smf_cell.sv
// One window cell: holds a sample and ranks it against the probes passing by.
module smf_cell
  import smf_pkg::*;
(
  input  logic                    clk_i,
  input  logic [SMF_IDX_W-1:0]    cell_idx_i,
  input  logic                    wr_en_i,
  input  logic [SMF_SAMPLE_W-1:0] wr_data_i,
  input  logic                    held_i,
  input  logic                    load_i,
  input  logic                    step_i,
  input  probe_t                  probe_i,
  output probe_t                  probe_o,
  output logic [SMF_SAMPLE_W-1:0] value_o,
  output logic [SMF_CNT_W-1:0]    rank_o
);

  logic [SMF_SAMPLE_W-1:0] value_q;
  probe_t                  probe_q;
  logic [SMF_CNT_W-1:0]    rank_q;
  logic                    hit;

  // A probe counts as below this sample if it is smaller, or equal and
  // from a lower cell, so every held sample gets a distinct rank.
  assign hit = probe_q.held &&
               ((probe_q.value < value_q) ||
                ((probe_q.value == value_q) && (probe_q.idx < cell_idx_i)));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      value_q <= wr_data_i;
    end
    if (load_i) begin
      probe_q <= '{value: value_q, idx: cell_idx_i, held: held_i};
      rank_q  <= '0;
    end else if (step_i) begin
      probe_q <= probe_i;
      rank_q  <= rank_q + SMF_CNT_W'(hit);
    end
  end

  assign probe_o = probe_q;
  assign value_o = value_q;
  assign rank_o  = rank_q;

endmodule

// File: design/sliding_median_filter_core.sv
// Top level of the sliding-window median filter built from a ring of ranking cells.
//
//   Channel   Direction  Beat contents
//   in_i      sink       sample (16 bits)
//   out_o     source     median (16 bits), samples_held (5 bits)
//   cfg_*     write      window_len (5 bits), no handshake
//
// A sample is accepted in the idle state, the probes are loaded in the load
// state, and ranking follows while the probes rotate once around the ring
// of 16 cells. The done state moves the median into the output register;
// only after that does the input take the next sample.
// Reset clears the window length to 8, the fill count and write position.
// A stalled output holds the result; the next sample may still be accepted
// and ranked, and it waits in the final state until the output is free.
module sliding_median_filter_core
  import smf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  smf_in_if.sink               in_i,
  smf_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [SMF_LEN_W-1:0] cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RANK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [SMF_IDX_W-1:0] step_q, step_d;
  logic [SMF_LEN_W-1:0] win_len_q;
  logic [SMF_IDX_W-1:0] wpos_q, wpos_d;
  logic [SMF_CNT_W-1:0] fill_q, fill_d;

  logic                    out_valid_q;
  logic [SMF_SAMPLE_W-1:0] median_q;
  logic [SMF_CNT_W-1:0]    held_cnt_q;

  logic [SMF_CNT_W-1:0] eff_len;
  logic                 accept;
  logic                 out_load;
  logic [SMF_IDX_W-1:0] wr_pos;
  logic [SMF_CNT_W-1:0] wr_next;

  probe_t                  probe   [SMF_DEPTH];
  logic [SMF_SAMPLE_W-1:0] value   [SMF_DEPTH];
  logic [SMF_CNT_W-1:0]    rank    [SMF_DEPTH];
  logic [SMF_DEPTH-1:0]    held;
  logic [SMF_DEPTH-1:0]    wr_sel;
  logic [SMF_SAMPLE_W-1:0] pick;

  // A length of zero behaves as one; anything past the ring saturates.
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = SMF_CNT_W'(1);
    end else if (SMF_CNT_W'(win_len_q) > SMF_CNT_W'(SMF_DEPTH)) begin
      eff_len = SMF_CNT_W'(SMF_DEPTH);
    end else begin
      eff_len = SMF_CNT_W'(win_len_q);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Write position and fill count advance as a sample is accepted; a config write clears both.
  always_comb begin
    wr_pos  = (SMF_CNT_W'(wpos_q) >= eff_len) ? '0 : wpos_q;
    wr_next = SMF_CNT_W'(wr_pos) + SMF_CNT_W'(1);
    wpos_d  = wpos_q;
    fill_d  = fill_q;
    if (cfg_we_i) begin
      wpos_d = '0;
      fill_d = '0;
    end else if (accept) begin
      wpos_d = (wr_next >= eff_len) ? '0 : wr_next[SMF_IDX_W-1:0];
      fill_d = (fill_q < eff_len) ? fill_q + SMF_CNT_W'(1) : eff_len;
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_RANK;
        step_d  = '0;
      end
      ST_RANK: begin
        step_d = step_q + SMF_IDX_W'(1);
        if (step_q == SMF_IDX_W'(SMF_DEPTH - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      win_len_q   <= SMF_LEN_RESET;
      wpos_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      wpos_q  <= wpos_d;
      fill_q  <= fill_d;
      if (cfg_we_i) begin
        win_len_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_q   <= pick;
      held_cnt_q <= fill_q;
    end
  end

  // The ring: each cell takes its probe from the cell before it.
  for (genvar i = 0; i < SMF_DEPTH; i++) begin : g_cell
    assign held[i]   = SMF_CNT_W'(i) < fill_q;
    assign wr_sel[i] = accept && (wr_pos == SMF_IDX_W'(i));

    smf_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (SMF_IDX_W'(i)),
      .wr_en_i    (wr_sel[i]),
      .wr_data_i  (in_i.sample),
      .held_i     (held[i]),
      .load_i     (state_q == ST_LOAD),
      .step_i     (state_q == ST_RANK),
      .probe_i    (probe[(i + SMF_DEPTH - 1) % SMF_DEPTH]),
      .probe_o    (probe[i]),
      .value_o    (value[i]),
      .rank_o     (rank[i])
    );
  end

  // Exactly one held cell carries the rank fill/2; its sample is the median.
  always_comb begin
    pick = '0;
    for (int i = 0; i < SMF_DEPTH; i++) begin
      if (held[i] && (rank[i] == (fill_q >> 1))) begin
        pick = pick | value[i];
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.median       = median_q;
  assign out_o.samples_held = SMF_LEN_W'(held_cnt_q);

endmodule

// File: verif/tb_sliding_median_filter_core.sv
// Self-checking testbench for the sliding median filter core.
`timescale 1ns / 100ps

module tb_sliding_median_filter_core;
  import smf_pkg::*;

  localparam int unsigned CLK_PERIOD      = 12;
  localparam int unsigned RESET_CYCLES    = 7;
  // The settle pause outlasts the pass of one beat through the ring.
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES     = 320;
  localparam int unsigned RANDOM_ITEMS    = 1750;
  localparam int unsigned WATCHDOG_CYCLES = 500_000;
  localparam int unsigned PLAN_LEN        = 18;

  // One expected output beat.
  typedef struct packed {
    logic [SMF_SAMPLE_W-1:0] median;
    logic [SMF_LEN_W-1:0]    held;
  } median_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [SMF_LEN_W-1:0] cfg_wdata_i;

  smf_in_if  in_bus ();
  smf_out_if out_bus ();

  sliding_median_filter_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Samples waiting to be offered, and medians waiting to come out.
  logic [SMF_SAMPLE_W-1:0] sample_queue [$];
  median_res_t             expected_medians [$];

  // Idle percentages of the two sides; changed only between phases.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  int unsigned results_seen;

  // Predictor state: the window register and a private copy of the ring.
  logic [SMF_LEN_W-1:0]    window_reg;
  logic [SMF_SAMPLE_W-1:0] ring_store [SMF_DEPTH];
  int unsigned             ring_wpos;
  int unsigned             ring_fill;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk_i = ~clk_i;
  end

  // The run is cut short here once the watchdog time runs out, as when the block stops making progress.
  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Takes one sample into the private ring and returns the median the block
  // should produce for it. A window of zero counts as one and anything above
  // the depth is clipped to the depth.
  function automatic median_res_t median_step(input logic [SMF_SAMPLE_W-1:0] s);
    int unsigned             len;
    int                      k;
    logic [SMF_SAMPLE_W-1:0] work [SMF_DEPTH];
    logic [SMF_SAMPLE_W-1:0] v;
    median_res_t             r;

    if (window_reg == '0) begin
      len = 1;
    end else if (32'(window_reg) > SMF_DEPTH) begin
      len = SMF_DEPTH;
    end else begin
      len = 32'(window_reg);
    end
    if (ring_wpos >= len) ring_wpos = 0;
    ring_store[ring_wpos] = s;
    ring_wpos++;
    if (ring_wpos >= len) ring_wpos = 0;
    if (ring_fill < len) ring_fill++;
    if (ring_fill > len) ring_fill = len;

    // Entries 0..fill-1 are exactly the held samples; sort a copy of them.
    for (int i = 0; i < ring_fill; i++) work[i] = ring_store[i];
    for (int i = 1; i < ring_fill; i++) begin
      v = work[i];
      k = i;
      while (k > 0 && work[k-1] > v) begin
        work[k] = work[k-1];
        k--;
      end
      work[k] = v;
    end
    r.median = work[ring_fill / 2];
    r.held   = SMF_LEN_W'(ring_fill);
    return r;
  endfunction

  // Sender: predicts each accepted beat, then offers the next queued sample
  // unless it decides to idle this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid  <= 1'b0;
      in_bus.sample <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_medians.push_back(median_step(in_bus.sample));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (sample_queue.size() != 0 &&
            !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
          in_bus.valid  <= 1'b1;
          in_bus.sample <= sample_queue.pop_front();
        end else begin
          in_bus.valid  <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output beat against the oldest prediction and
  // drives ready. Every 500 results it holds ready low for a long stretch,
  // so the block fills up and must stall its input while the sender keeps
  // offering samples.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned hold_left;
    median_res_t want;
    logic        ready_next;

    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("unexpected beat median=%h held=%0d",
                                    out_bus.median, out_bus.samples_held));
        end else begin
          want = expected_medians.pop_front();
          if (out_bus.median !== want.median) begin
            report_mismatch($sformatf("median %h, predicted %h",
                                      out_bus.median, want.median));
          end
          if (out_bus.samples_held !== want.held) begin
            report_mismatch($sformatf("samples_held %0d, predicted %0d",
                                      out_bus.samples_held, want.held));
          end
        end
        if (results_seen % 500 == 250) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
      out_bus.ready <= ready_next;
    end
  end

  // Waits until every queued sample is taken and every median has come out,
  // then lets the ring settle before the window may be rewritten.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_bus.valid) @(negedge clk_i);
    while (expected_medians.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes the window length; the block restarts filling from position zero.
  task automatic write_window(input logic [SMF_LEN_W-1:0] len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_reg = len;
    ring_wpos  = 0;
    ring_fill  = 0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [SMF_LEN_W-1:0]    window_plan [PLAN_LEN];
    logic [SMF_SAMPLE_W-1:0] base;
    logic [SMF_SAMPLE_W-1:0] step;
    int unsigned             sent;
    int unsigned             phase;
    int unsigned             count;
    int unsigned             style;

    // Zero and anything above the depth exercise the clamping of the length.
    window_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd3, 5'd16,
                    5'd9, 5'd15, 5'd4, 5'd12, 5'd7, 5'd6, 5'd11, 5'd13, 5'd10};

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_bus.valid  = 1'b0;
    in_bus.sample = '0;
    out_bus.ready = 1'b0;
    window_reg    = SMF_LEN_RESET;
    ring_wpos     = 0;
    ring_fill     = 0;
    error_count   = 0;
    results_seen  = 0;
    send_idle_pct = 26;
    recv_idle_pct = 50;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset window of eight: extremes, ties, and
    // enough samples to wrap the write position past the window end.
    sample_queue = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
                     16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF};
    wait_idle();
    // A restart before the window has filled, then a refill over the stale
    // contents of the store.
    write_window(5'd4);
    sample_queue = '{16'h1234, 16'hFFFF, 16'h0000};
    wait_idle();
    write_window(5'd4);
    sample_queue = '{16'h0002, 16'h0001, 16'h0003, 16'h0000, 16'hFFFF};
    wait_idle();

    // Random phases, each with its own window length and sample style.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < 600) begin
        send_idle_pct = 26;
        recv_idle_pct = 50;
      end else if (sent < 1200) begin
        send_idle_pct = 50;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_window(window_plan[phase % PLAN_LEN]);
      // Mostly long phases; now and then a short one that restarts mid-fill.
      count = ($urandom_range(3) == 0) ? $urandom_range(1, 15) : $urandom_range(40, 170);
      style = $urandom_range(3);
      base  = SMF_SAMPLE_W'($urandom);
      step  = SMF_SAMPLE_W'($urandom_range(1, 300));
      for (int i = 0; i < count; i++) begin
        case (style)
          0: sample_queue.push_back(SMF_SAMPLE_W'($urandom));
          // A narrow band gives many equal samples in the window.
          1: sample_queue.push_back(base + SMF_SAMPLE_W'($urandom_range(7)));
          2: begin
            case ($urandom_range(3))
              0: sample_queue.push_back(16'h0000);
              1: sample_queue.push_back(16'hFFFF);
              2: sample_queue.push_back(16'h8000);
              default: sample_queue.push_back(16'h7FFF);
            endcase
          end
          default: begin
            // Ramps, rising or falling, wrapping through the full range.
            sample_queue.push_back(base);
            base = (phase[0]) ? base + step : base - step;
          end
        endcase
      end
      sent += count;
      phase++;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
